/* rtl/core/dfv_pkg.sv */
package dfv_pkg;

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MAX_FRAME_BYTES = 7'd64;
  localparam logic [CNT_W-1:0] ACK_BYTES = 7'd8;
  localparam logic [CNT_W-1:0] TM_BYTES = 7'd38;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] FRAME_HEADER = 16'hAA55;
  localparam logic [7:0] TM_TYPE = 8'h01;

  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    V_ACK_OK      = 3'd0,
    V_ACK_BAD_HDR = 3'd1,
    V_ACK_BAD_SEQ = 3'd2,
    V_ACK_BAD_CRC = 3'd3,
    V_TM_OK       = 3'd4,
    V_TM_BAD_HDR  = 3'd5,
    V_TM_BAD_CRC  = 3'd6,
    V_BAD_LEN     = 3'd7
  } verdict_t;

  // what the byte stage hands over at the end of a frame
  typedef struct packed {
    logic [CNT_W-1:0] length;
    logic [15:0]      crc;
    logic [15:0]      checksum;
    logic [15:0]      header;
    logic [15:0]      seq;
    logic [7:0]       byte_four;
    logic [7:0]       byte_five;
  } frame_sum_t;

  // msb-first, no reflection, no final xor
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/dfv_byte_stage.sv */
module dfv_byte_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte
  input  logic                   in_tlast,   // last_byte
  input  logic                   sum_ready,
  input  logic                   out_full,
  output logic                   sum_valid,
  output dfv_pkg::frame_sum_t    sum
);
  import dfv_pkg::*;

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       dly0_r, dly1_r;
  logic [15:0]      hdr_r, hdr_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [7:0]       b4_r, b4_nxt;
  logic [7:0]       b5_r, b5_nxt;
  logic             sum_valid_r;
  frame_sum_t       sum_r;
  logic             accept;

  // ready decoded from registered state: stall only when both the summary and result slots hold data
  assign in_tready = !(sum_valid_r && out_full);
  assign accept    = in_tvalid && in_tready;
  assign sum_valid = sum_valid_r;
  assign sum       = sum_r;

  always_comb begin
    crc_nxt = (cnt_r >= 7'd2) ? crc_feed(crc_r, dly0_r) : crc_r;
    hdr_nxt = hdr_r;
    seq_nxt = seq_r;
    b4_nxt  = b4_r;
    b5_nxt  = b5_r;
    unique case (cnt_r)
      7'd0:    hdr_nxt = {hdr_r[15:8], in_tdata};
      7'd1:    hdr_nxt = {in_tdata, hdr_r[7:0]};
      7'd2:    seq_nxt = {seq_r[15:8], in_tdata};
      7'd3:    seq_nxt = {in_tdata, seq_r[7:0]};
      7'd4:    b4_nxt  = in_tdata;
      7'd5:    b5_nxt  = in_tdata;
      default: ;
    endcase
    cnt_nxt = (cnt_r < MAX_FRAME_BYTES) ? cnt_r + 7'd1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      cnt_r       <= '0;
      dly0_r      <= '0;
      dly1_r      <= '0;
      hdr_r       <= '0;
      seq_r       <= '0;
      b4_r        <= '0;
      b5_r        <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      // a new summary may land in the same cycle the old one moves on
      if (accept && in_tlast) sum_valid_r <= 1'b1;
      else if (sum_valid_r && sum_ready) sum_valid_r <= 1'b0;
      if (accept) begin
        if (in_tlast) begin
          crc_r  <= CRC_INIT;
          cnt_r  <= '0;
          dly0_r <= '0;
          dly1_r <= '0;
          hdr_r  <= '0;
          seq_r  <= '0;
          b4_r   <= '0;
          b5_r   <= '0;
        end else begin
          crc_r  <= crc_nxt;
          cnt_r  <= cnt_nxt;
          dly0_r <= dly1_r;
          dly1_r <= in_tdata;
          hdr_r  <= hdr_nxt;
          seq_r  <= seq_nxt;
          b4_r   <= b4_nxt;
          b5_r   <= b5_nxt;
        end
      end
    end
  end

  // checksum is the two newest bytes, little endian
  always_ff @(posedge clk) begin
    if (accept && in_tlast) begin
      sum_r.length    <= cnt_nxt;
      sum_r.crc       <= crc_nxt;
      sum_r.checksum  <= {in_tdata, dly1_r};
      sum_r.header    <= hdr_nxt;
      sum_r.seq       <= seq_nxt;
      sum_r.byte_four <= b4_nxt;
      sum_r.byte_five <= b5_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_FRAME_BYTES)
    else $error("byte count beyond saturation");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> cnt_r == '0 && crc_r == CRC_INIT && sum_valid_r)
    else $error("frame state not cleared after last item");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    sum_valid_r && !sum_ready && out_full |-> !in_tready)
    else $error("summary overwritten while held");

endmodule

/* rtl/core/dfv_verdict_stage.sv */
module dfv_verdict_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            sum_valid,
  input  dfv_pkg::frame_sum_t             sum,
  output logic                            sum_ready,
  output logic                            out_full,
  input  logic [15:0]                     expected_ack_seq,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // frame_length, frame_seq, cmd_code, ack_status, sys_state,
  // seq_delta, delta_valid, loss_seen, zero fill
  output logic [dfv_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [2:0]                      out_tuser   // verdict
);
  import dfv_pkg::*;

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  verdict_t    verdict_r, verdict_c;
  logic [15:0] prev_seq_r;
  logic        prev_valid_r;
  logic        move;
  logic [7:0]  cmd_c, ast_c, sst_c;
  logic [15:0] delta_c;
  logic        dvalid_c, loss_c;
  logic        crc_ok;

  assign sum_ready  = !out_valid_r || out_tready;
  assign move       = sum_valid && sum_ready;
  assign out_full   = out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = verdict_r;
  assign crc_ok     = sum.crc == sum.checksum;

  always_comb begin
    cmd_c    = '0;
    ast_c    = '0;
    sst_c    = '0;
    delta_c  = '0;
    dvalid_c = 1'b0;
    loss_c   = 1'b0;
    if (sum.length == ACK_BYTES) begin
      cmd_c = sum.byte_four;
      ast_c = sum.byte_five;
      priority if (sum.header != FRAME_HEADER) verdict_c = V_ACK_BAD_HDR;
      else if (sum.seq != expected_ack_seq)    verdict_c = V_ACK_BAD_SEQ;
      else if (!crc_ok)                        verdict_c = V_ACK_BAD_CRC;
      else                                     verdict_c = V_ACK_OK;
    end else if (sum.length == TM_BYTES) begin
      sst_c = sum.byte_five;
      priority if (sum.header != FRAME_HEADER || sum.byte_four != TM_TYPE)
        verdict_c = V_TM_BAD_HDR;
      else if (!crc_ok) verdict_c = V_TM_BAD_CRC;
      else begin
        verdict_c = V_TM_OK;
        if (prev_valid_r) begin
          delta_c  = sum.seq - prev_seq_r;
          dvalid_c = 1'b1;
          loss_c   = delta_c != 16'd1;
        end
      end
    end else begin
      verdict_c = V_BAD_LEN;
    end
    data_nxt = {7'd0, loss_c, dvalid_c, delta_c, sst_c, ast_c, cmd_c, sum.seq, sum.length};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      prev_seq_r   <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      if (move) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (move && verdict_c == V_TM_OK) begin
        prev_seq_r   <= sum.seq;
        prev_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      data_r    <= data_nxt;
      verdict_r <= verdict_c;
    end
  end

  a_loss_needs_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!data_r[64] || data_r[63]))
    else $error("loss flag without a valid delta");

  a_delta_only_tm_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && data_r[63] |-> verdict_r == V_TM_OK)
    else $error("delta reported on a frame other than good telemetry");

  a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    move && verdict_c == V_TM_OK |=> prev_valid_r && prev_seq_r == $past(sum.seq))
    else $error("previous telemetry sequence not updated");

endmodule

/* rtl/core/downlink_frame_validator.sv */
// the byte stage registers a frame's summary, then the verdict stage its result
// throughput: one byte per cycle; ready drops only while a summary and a result
//   both wait, even when the output takes the result in that cycle
// reset: synchronous active-low rst_n clears frame state, crc to all ones,
//   the expected ack sequence and the telemetry history; no clearing pass
module downlink_frame_validator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tlast,   // last_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // frame_length, frame_seq, cmd_code, ack_status, sys_state,
  // seq_delta, delta_valid, loss_seen, zero fill
  output logic [dfv_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]                     out_tuser,  // verdict
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [15:0]                    cfg_data    // expected_ack_seq
);
  import dfv_pkg::*;

  logic [15:0] exp_seq_r;
  logic        sum_valid, sum_ready, out_full;
  frame_sum_t  sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      exp_seq_r <= cfg_data;
    end
  end

  dfv_byte_stage u_byte (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .sum_ready (sum_ready),
    .out_full  (out_full),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  dfv_verdict_stage u_verdict (
    .clk              (clk),
    .rst_n            (rst_n),
    .sum_valid        (sum_valid),
    .sum              (sum),
    .sum_ready        (sum_ready),
    .out_full         (out_full),
    .expected_ack_seq (exp_seq_r),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser)
  );

endmodule
